// ===== src/rsmef_pkg.sv =====
// Shared types, constants and the median helper function of the range sensor filter.
package rsmef_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int EMA_FRACTION_BITS = 8;
	localparam int ALPHA_BITS        = 8;
	localparam int ALPHA_W           = ALPHA_BITS + 1;
	localparam int EMA_W             = SAMPLE_BITS + EMA_FRACTION_BITS;
	localparam int ACC_W             = EMA_W + ALPHA_BITS + 2;
	localparam int WINDOW_DEPTH      = 3;
	localparam int SLOT_W            = 2;

	localparam int NUM_REGS   = 5;
	localparam int CFG_ADDR_W = $clog2(4 * NUM_REGS);
	localparam int REG_IDX_W  = CFG_ADDR_W - 2;
	localparam int APB_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_MAX_JUMP     = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_EMA_ALPHA    = REG_IDX_W'(4);

	localparam logic [SAMPLE_BITS-1:0] RST_MIN_DISTANCE = SAMPLE_BITS'(20);
	localparam logic [SAMPLE_BITS-1:0] RST_MAX_DISTANCE = SAMPLE_BITS'(2000);
	localparam logic [SAMPLE_BITS-1:0] RST_MAX_JUMP     = SAMPLE_BITS'(200);
	localparam logic [SAMPLE_BITS-1:0] RST_CAL_OFFSET   = SAMPLE_BITS'(0);
	localparam logic [ALPHA_W-1:0]     RST_EMA_ALPHA    = ALPHA_W'(77);

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_BITS);

	typedef enum logic [1:0] {
		ACT_FILTER = 2'd0,
		ACT_SEED   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef struct packed {
		logic        [SAMPLE_BITS-1:0] min_distance;
		logic        [SAMPLE_BITS-1:0] max_distance;
		logic        [SAMPLE_BITS-1:0] max_jump;
		logic signed [SAMPLE_BITS-1:0] calibration_offset;
		logic        [ALPHA_W-1:0]     ema_alpha;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] filtered;
		logic                   in_range;
		logic                   jump_rejected;
		logic                   primed;
	} result_t;

	function automatic logic [SAMPLE_BITS-1:0] mid_of_three(
		input logic [SAMPLE_BITS-1:0] x,
		input logic [SAMPLE_BITS-1:0] y,
		input logic [SAMPLE_BITS-1:0] z
	);
		logic [SAMPLE_BITS-1:0] lo;
		logic [SAMPLE_BITS-1:0] hi;
		lo = (x > y) ? y : x;
		hi = (x > y) ? x : y;
		if (z >= hi) begin
			return hi;
		end else if (z <= lo) begin
			return lo;
		end
		return z;
	endfunction

endpackage

// ===== src/range_sensor_median_ema_filter_unit.sv =====
// Top level of the range sensor median and EMA filter with its handshakes.
//
//   Channel   Direction   Handshake                    Payload
//   sample    in          sample_valid / sample_stall  action, sample
//   result    out         result_valid / result_stall  filtered, in_range, jump_rejected, primed
//   config    in          APB psel/penable/pwrite      paddr, pwdata -> prdata
//
// An item passes from its transfer into the input register and then through the filter update
// into the result register; one item per cycle is sustained while the result side does not stall.
// The filter state is updated in the same cycle the item moves into the result register.
// Reset clears the filter state, the handshake flags and restores the register defaults.
// A stalled result holds its register; the input register then stalls once it is full.
module range_sensor_median_ema_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [1:0]                           action,
	input  logic [rsmef_pkg::SAMPLE_BITS-1:0]    sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [rsmef_pkg::SAMPLE_BITS-1:0]    filtered,
	output logic                                 in_range,
	output logic                                 jump_rejected,
	output logic                                 primed,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rsmef_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rsmef_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rsmef_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready
);

	rsmef_pkg::cfg_t                     cfg;
	rsmef_pkg::result_t                  core_res;
	rsmef_pkg::result_t                  res_q;
	logic                                valid_s1;
	logic [1:0]                          action_s1;
	logic [rsmef_pkg::SAMPLE_BITS-1:0]   sample_s1;
	logic                                res_valid_q;
	logic                                advance;
	logic                                go;
	logic                                accept;

	assign advance      = !res_valid_q || !result_stall;
	assign go           = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			sample_s1 <= sample;
		end
	end

	rsmef_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rsmef_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.action (action_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= core_res;
		end
	end

	assign result_valid  = res_valid_q;
	assign filtered      = res_q.filtered;
	assign in_range      = res_q.in_range;
	assign jump_rejected = res_q.jump_rejected;
	assign primed        = res_q.primed;

	// A clear transfer leaves an all-zero result behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		go && action_s1 == rsmef_pkg::ACT_CLEAR |=>
		result_valid && filtered == '0 && !in_range && !primed && !jump_rejected)
	else $error("clear did not produce an all-zero result");

	// A jump rejection only happens on a primed filter with an in-range sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && jump_rejected |-> primed && in_range)
	else $error("jump rejection reported on unprimed or out-of-range result");

	// Every item leaving the input register lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		go |=> result_valid)
	else $error("processed item did not reach the result register");

	// The input side only stalls while the input register holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && result_valid && result_stall)
	else $error("input stalled without a blocked result");

endmodule

// ===== src/rsmef_cfg_regs.sv =====
// APB register file holding the filter configuration.
module rsmef_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rsmef_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rsmef_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rsmef_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	output rsmef_pkg::cfg_t                      cfg
);

	rsmef_pkg::cfg_t                    cfg_q;
	logic [rsmef_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                               wr_en;

	assign reg_idx = paddr[rsmef_pkg::CFG_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_distance       <= rsmef_pkg::RST_MIN_DISTANCE;
			cfg_q.max_distance       <= rsmef_pkg::RST_MAX_DISTANCE;
			cfg_q.max_jump           <= rsmef_pkg::RST_MAX_JUMP;
			cfg_q.calibration_offset <= rsmef_pkg::RST_CAL_OFFSET;
			cfg_q.ema_alpha          <= rsmef_pkg::RST_EMA_ALPHA;
		end else if (wr_en) begin
			case (reg_idx)
				rsmef_pkg::REG_MIN_DISTANCE: begin
					cfg_q.min_distance <= pwdata[rsmef_pkg::SAMPLE_BITS-1:0];
				end
				rsmef_pkg::REG_MAX_DISTANCE: begin
					cfg_q.max_distance <= pwdata[rsmef_pkg::SAMPLE_BITS-1:0];
				end
				rsmef_pkg::REG_MAX_JUMP: begin
					cfg_q.max_jump <= pwdata[rsmef_pkg::SAMPLE_BITS-1:0];
				end
				rsmef_pkg::REG_CAL_OFFSET: begin
					cfg_q.calibration_offset <= $signed(pwdata[rsmef_pkg::SAMPLE_BITS-1:0]);
				end
				rsmef_pkg::REG_EMA_ALPHA: begin
					cfg_q.ema_alpha <= pwdata[rsmef_pkg::ALPHA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rsmef_pkg::REG_MIN_DISTANCE: begin
				prdata = rsmef_pkg::APB_DATA_W'(cfg_q.min_distance);
			end
			rsmef_pkg::REG_MAX_DISTANCE: begin
				prdata = rsmef_pkg::APB_DATA_W'(cfg_q.max_distance);
			end
			rsmef_pkg::REG_MAX_JUMP: begin
				prdata = rsmef_pkg::APB_DATA_W'(cfg_q.max_jump);
			end
			rsmef_pkg::REG_CAL_OFFSET: begin
				prdata = rsmef_pkg::APB_DATA_W'($unsigned(cfg_q.calibration_offset));
			end
			rsmef_pkg::REG_EMA_ALPHA: begin
				prdata = rsmef_pkg::APB_DATA_W'(cfg_q.ema_alpha);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== src/rsmef_core.sv =====
// Filter state and the combinational range, median, jump and EMA update, registered on go.
module rsmef_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic [1:0]                            action,
	input  logic [rsmef_pkg::SAMPLE_BITS-1:0]     sample,
	input  rsmef_pkg::cfg_t                       cfg,
	output rsmef_pkg::result_t                    result
);

	localparam int SB = rsmef_pkg::SAMPLE_BITS;
	localparam int FB = rsmef_pkg::EMA_FRACTION_BITS;
	localparam int EW = rsmef_pkg::EMA_W;
	localparam int AW = rsmef_pkg::ALPHA_W;
	localparam int CW = rsmef_pkg::ACC_W;

	logic [SB-1:0]                 window_q [rsmef_pkg::WINDOW_DEPTH];
	logic [rsmef_pkg::SLOT_W-1:0]  slot_q;
	logic [SB-1:0]                 last_median_q;
	logic [EW-1:0]                 ema_q;
	logic [SB-1:0]                 held_q;
	logic                          primed_q;
	logic                          valid_q;

	logic [SB-1:0]                 window_n [rsmef_pkg::WINDOW_DEPTH];
	logic [rsmef_pkg::SLOT_W-1:0]  slot_n;
	logic [SB-1:0]                 last_median_n;
	logic [EW-1:0]                 ema_n;
	logic [SB-1:0]                 held_n;
	logic                          primed_n;
	logic                          valid_n;
	logic                          rejected;

	logic signed [SB+1:0]          cal_sum;
	logic signed [SB+1:0]          lo_s;
	logic signed [SB+1:0]          hi_s;
	logic [SB-1:0]                 cal;
	logic [SB-1:0]                 med;
	logic [SB-1:0]                 jump;
	logic [AW-1:0]                 alpha_sat;
	logic [CW-1:0]                 acc;
	logic [EW-1:0]                 ema_upd;

	assign alpha_sat = (cfg.ema_alpha > rsmef_pkg::ALPHA_ONE) ? rsmef_pkg::ALPHA_ONE
	                                                          : cfg.ema_alpha;

	// Offset and clamp; only used when the raw reading is inside the bounds.
	always_comb begin
		cal_sum = $signed({2'b00, sample}) + $signed({{2{cfg.calibration_offset[SB-1]}},
		                                             cfg.calibration_offset});
		lo_s    = $signed({2'b00, cfg.min_distance});
		hi_s    = $signed({2'b00, cfg.max_distance});
		if (cal_sum < lo_s) begin
			cal = cfg.min_distance;
		end else if (cal_sum > hi_s) begin
			cal = cfg.max_distance;
		end else begin
			cal = cal_sum[SB-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
			window_n[i] = window_q[i];
		end
		slot_n        = slot_q;
		last_median_n = last_median_q;
		ema_n         = ema_q;
		held_n        = held_q;
		primed_n      = primed_q;
		valid_n       = valid_q;
		rejected      = 1'b0;
		med           = '0;
		jump          = '0;
		acc           = '0;
		ema_upd       = '0;
		case (rsmef_pkg::action_t'(action))
			rsmef_pkg::ACT_CLEAR: begin
				for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
					window_n[i] = '0;
				end
				slot_n        = '0;
				last_median_n = '0;
				ema_n         = '0;
				held_n        = '0;
				primed_n      = 1'b0;
				valid_n       = 1'b0;
			end
			rsmef_pkg::ACT_SEED: begin
				for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
					window_n[i] = sample;
				end
				slot_n        = '0;
				last_median_n = sample;
				ema_n         = {sample, {FB{1'b0}}};
				held_n        = sample;
				primed_n      = 1'b1;
				valid_n       = 1'b1;
			end
			rsmef_pkg::ACT_FILTER: begin
				if (sample < cfg.min_distance || sample > cfg.max_distance) begin
					valid_n = 1'b0;
				end else if (!primed_q) begin
					for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
						window_n[i] = cal;
					end
					slot_n        = '0;
					last_median_n = cal;
					ema_n         = {cal, {FB{1'b0}}};
					held_n        = cal;
					primed_n      = 1'b1;
					valid_n       = 1'b1;
				end else begin
					valid_n = 1'b1;
					for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
						if (slot_q == rsmef_pkg::SLOT_W'(i)) begin
							window_n[i] = cal;
						end
					end
					slot_n = (slot_q == rsmef_pkg::SLOT_W'(rsmef_pkg::WINDOW_DEPTH - 1))
					         ? '0 : slot_q + 1'b1;
					med  = rsmef_pkg::mid_of_three(window_n[0], window_n[1], window_n[2]);
					jump = (med > last_median_q) ? med - last_median_q : last_median_q - med;
					acc  = CW'(alpha_sat) * CW'({med, {FB{1'b0}}})
					     + CW'(rsmef_pkg::ALPHA_ONE - alpha_sat) * CW'(ema_q);
					ema_upd = acc[rsmef_pkg::ALPHA_BITS +: EW];
					if (jump > cfg.max_jump) begin
						rejected = 1'b1;
					end else begin
						last_median_n = med;
						ema_n         = ema_upd;
						held_n        = ema_upd[FB +: SB];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
				window_q[i] <= '0;
			end
			slot_q        <= '0;
			last_median_q <= '0;
			ema_q         <= '0;
			held_q        <= '0;
			primed_q      <= 1'b0;
			valid_q       <= 1'b0;
		end else if (go) begin
			for (int i = 0; i < rsmef_pkg::WINDOW_DEPTH; i++) begin
				window_q[i] <= window_n[i];
			end
			slot_q        <= slot_n;
			last_median_q <= last_median_n;
			ema_q         <= ema_n;
			held_q        <= held_n;
			primed_q      <= primed_n;
			valid_q       <= valid_n;
		end
	end

	assign result.filtered      = held_n;
	assign result.in_range      = valid_n;
	assign result.jump_rejected = rejected;
	assign result.primed        = primed_n;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the range sensor median and EMA filter top level.
module testbench;

	typedef rsmef_pkg::cfg_t    cfg_t;
	typedef rsmef_pkg::result_t result_t;

	localparam int SAMPLE_BITS       = rsmef_pkg::SAMPLE_BITS;
	localparam int EMA_FRACTION_BITS = rsmef_pkg::EMA_FRACTION_BITS;
	localparam int ALPHA_BITS        = rsmef_pkg::ALPHA_BITS;
	localparam int ALPHA_W           = rsmef_pkg::ALPHA_W;
	localparam int EMA_W             = rsmef_pkg::EMA_W;
	localparam int WINDOW_DEPTH      = rsmef_pkg::WINDOW_DEPTH;
	localparam int SLOT_W            = rsmef_pkg::SLOT_W;
	localparam int NUM_REGS          = rsmef_pkg::NUM_REGS;
	localparam int CFG_ADDR_W        = rsmef_pkg::CFG_ADDR_W;
	localparam int REG_IDX_W         = rsmef_pkg::REG_IDX_W;
	localparam int APB_DATA_W        = rsmef_pkg::APB_DATA_W;

	localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE = rsmef_pkg::REG_MIN_DISTANCE;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = rsmef_pkg::REG_MAX_DISTANCE;
	localparam logic [REG_IDX_W-1:0] REG_MAX_JUMP     = rsmef_pkg::REG_MAX_JUMP;
	localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET   = rsmef_pkg::REG_CAL_OFFSET;
	localparam logic [REG_IDX_W-1:0] REG_EMA_ALPHA    = rsmef_pkg::REG_EMA_ALPHA;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = rsmef_pkg::ALPHA_ONE;

	localparam logic [1:0] ACT_FILTER    = rsmef_pkg::ACT_FILTER;
	localparam logic [1:0] ACT_SEED      = rsmef_pkg::ACT_SEED;
	localparam logic [1:0] ACT_CLEAR     = rsmef_pkg::ACT_CLEAR;
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;
	localparam int NUM_DIRECTED   = 23;
	localparam int PHASE_ITEMS    = 145;
	localparam int NUM_PHASES     = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic [1:0]             action       = ACT_FILTER;
	logic [SAMPLE_BITS-1:0] sample       = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [SAMPLE_BITS-1:0] filtered;
	logic                   in_range;
	logic                   jump_rejected;
	logic                   primed;
	logic                   psel         = 1'b0;
	logic                   penable      = 1'b0;
	logic                   pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr        = '0;
	logic [APB_DATA_W-1:0]  pwdata       = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	range_sensor_median_ema_filter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.action(action),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.filtered(filtered),
		.in_range(in_range),
		.jump_rejected(jump_rejected),
		.primed(primed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	typedef struct {
		logic [1:0]             act;
		logic [SAMPLE_BITS-1:0] value;
		bit                     typed;
		logic [SAMPLE_BITS-1:0] want_filtered;
		logic                   want_in_range;
		logic                   want_rejected;
		logic                   want_primed;
	} directed_row_t;

	// Copy of the register file and of the filter state, kept in step with the block.
	cfg_t                   shadow_cfg;
	logic [SAMPLE_BITS-1:0] mdl_window [WINDOW_DEPTH];
	logic [SLOT_W-1:0]      mdl_slot;
	logic [SAMPLE_BITS-1:0] mdl_last_median;
	logic [EMA_W-1:0]       mdl_ema;
	logic [SAMPLE_BITS-1:0] mdl_held;
	logic                   mdl_primed;
	logic                   mdl_valid;

	result_t       expected_results [$];
	directed_row_t directed_rows [NUM_DIRECTED];

	bit quiet_mode      = 1'b0;
	int error_count     = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int rejects_seen    = 0;
	int out_of_range    = 0;
	int seeds_sent      = 0;
	int clears_sent     = 0;
	int settings_used   = 0;
	int idle_cycles     = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch: %s got %0d expected %0d (result %0d, t=%0t)",
			what, got, want, results_checked, $realtime);
		error_count++;
	endtask

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_filter_model();
		for (int i = 0; i < WINDOW_DEPTH; i++) mdl_window[i] = '0;
		mdl_slot        = '0;
		mdl_last_median = '0;
		mdl_ema         = '0;
		mdl_held        = '0;
		mdl_primed      = 1'b0;
		mdl_valid       = 1'b0;
	endfunction

	function automatic void prime_filter_model(input logic [SAMPLE_BITS-1:0] v);
		for (int i = 0; i < WINDOW_DEPTH; i++) mdl_window[i] = v;
		mdl_slot        = '0;
		mdl_last_median = v;
		mdl_ema         = {v, {EMA_FRACTION_BITS{1'b0}}};
		mdl_held        = v;
		mdl_primed      = 1'b1;
		mdl_valid       = 1'b1;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] middle_sample(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] c);
		if ((a >= b && a <= c) || (a <= b && a >= c)) return a;
		if ((b >= a && b <= c) || (b <= a && b >= c)) return b;
		return c;
	endfunction

	// Advances the filter copy by one item and returns the result it should produce.
	function automatic result_t predict_filter_step(input logic [1:0] act,
		input logic [SAMPLE_BITS-1:0] raw);
		result_t                res;
		int                     corrected;
		logic [SAMPLE_BITS-1:0] cal;
		logic [SAMPLE_BITS-1:0] med;
		logic [SAMPLE_BITS-1:0] diff;
		logic [ALPHA_W-1:0]     weight;
		logic [39:0]            acc;
		bit                     rejected;
		rejected = 1'b0;
		if (act == ACT_CLEAR) begin
			clear_filter_model();
		end else if (act == ACT_SEED) begin
			prime_filter_model(raw);
		end else if (act == ACT_FILTER) begin
			if (raw < shadow_cfg.min_distance || raw > shadow_cfg.max_distance) begin
				mdl_valid = 1'b0;
			end else begin
				corrected = int'(raw) + int'(shadow_cfg.calibration_offset);
				if (corrected < int'(shadow_cfg.min_distance))
					corrected = int'(shadow_cfg.min_distance);
				if (corrected > int'(shadow_cfg.max_distance))
					corrected = int'(shadow_cfg.max_distance);
				cal = corrected[SAMPLE_BITS-1:0];
				mdl_valid = 1'b1;
				if (!mdl_primed) begin
					prime_filter_model(cal);
				end else begin
					mdl_window[mdl_slot] = cal;
					mdl_slot = (mdl_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : mdl_slot + 1'b1;
					med = middle_sample(mdl_window[0], mdl_window[1], mdl_window[2]);
					diff = (med > mdl_last_median) ? med - mdl_last_median
						: mdl_last_median - med;
					if (diff > shadow_cfg.max_jump) begin
						rejected = 1'b1;
					end else begin
						weight = (shadow_cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE
							: shadow_cfg.ema_alpha;
						acc = 40'(weight) * 40'({med, {EMA_FRACTION_BITS{1'b0}}})
							+ 40'(ALPHA_ONE - weight) * 40'(mdl_ema);
						mdl_last_median = med;
						mdl_ema = acc[EMA_W+ALPHA_BITS-1:ALPHA_BITS];
						mdl_held = mdl_ema[EMA_W-1:EMA_FRACTION_BITS];
					end
				end
			end
		end
		res.filtered      = mdl_held;
		res.in_range      = mdl_valid;
		res.jump_rejected = rejected;
		res.primed        = mdl_primed;
		return res;
	endfunction

	// Offers one item, waits for its transfer and records what it should produce.
	task automatic send_item(input logic [1:0] act, input logic [SAMPLE_BITS-1:0] value,
		input bit typed, input result_t typed_want);
		int      gap;
		result_t predicted;
		gap = idle_length();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		action       <= act;
		sample       <= value;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		predicted = predict_filter_step(act, value);
		expected_results.push_back(typed ? typed_want : predicted);
		items_sent++;
		if (predicted.jump_rejected) rejects_seen++;
		if (act == ACT_FILTER && !predicted.in_range) out_of_range++;
		if (act == ACT_SEED) seeds_sent++;
		if (act == ACT_CLEAR) clears_sent++;
	endtask

	task automatic wait_until_drained();
		sample_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Back-to-back transfers keep psel high; apb_release ends a batch.
	task automatic apb_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [APB_DATA_W-1:0] register_mask(input logic [REG_IDX_W-1:0] idx);
		return (idx == REG_EMA_ALPHA) ? APB_DATA_W'((1 << ALPHA_W) - 1)
			: APB_DATA_W'((1 << SAMPLE_BITS) - 1);
	endfunction

	function automatic logic [APB_DATA_W-1:0] shadow_register(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_MIN_DISTANCE: return APB_DATA_W'(shadow_cfg.min_distance);
			REG_MAX_DISTANCE: return APB_DATA_W'(shadow_cfg.max_distance);
			REG_MAX_JUMP:     return APB_DATA_W'(shadow_cfg.max_jump);
			REG_CAL_OFFSET:   return APB_DATA_W'(unsigned'(shadow_cfg.calibration_offset));
			default:          return APB_DATA_W'(shadow_cfg.ema_alpha);
		endcase
	endfunction

	task automatic check_registers();
		logic [APB_DATA_W-1:0] rdata;
		logic [APB_DATA_W-1:0] mask;
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_access(1'b0, REG_IDX_W'(i), '0, rdata);
			mask = register_mask(REG_IDX_W'(i));
			if ((rdata & mask) !== shadow_register(REG_IDX_W'(i)))
				report_mismatch($sformatf("register %0d readback", i), rdata & mask,
					shadow_register(REG_IDX_W'(i)));
		end
		apb_release();
	endtask

	// The upper data bits carry junk so that the register masking is exercised too.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		logic [APB_DATA_W-1:0] mask;
		logic [APB_DATA_W-1:0] data;
		logic [APB_DATA_W-1:0] unused;
		mask = register_mask(idx);
		data = ($urandom & ~mask) | (value & mask);
		apb_access(1'b1, idx, data, unused);
		case (idx)
			REG_MIN_DISTANCE: shadow_cfg.min_distance       = data[SAMPLE_BITS-1:0];
			REG_MAX_DISTANCE: shadow_cfg.max_distance       = data[SAMPLE_BITS-1:0];
			REG_MAX_JUMP:     shadow_cfg.max_jump           = data[SAMPLE_BITS-1:0];
			REG_CAL_OFFSET:   shadow_cfg.calibration_offset = data[SAMPLE_BITS-1:0];
			default:          shadow_cfg.ema_alpha          = data[ALPHA_W-1:0];
		endcase
	endtask

	task automatic apply_settings(input int lo, input int hi, input int jump, input int offset,
		input int alpha);
		wait_until_drained();
		write_register(REG_MIN_DISTANCE, 32'(lo));
		write_register(REG_MAX_DISTANCE, 32'(hi));
		write_register(REG_MAX_JUMP, 32'(jump));
		write_register(REG_CAL_OFFSET, 32'(offset));
		write_register(REG_EMA_ALPHA, 32'(alpha));
		apb_release();
		check_registers();
		settings_used++;
		quiet_mode = ($urandom_range(0, 3) == 0);
	endtask

	// Mostly a slowly moving distance with noise, plus spikes, range misses and commands.
	task automatic run_phase(input int n_items);
		int      lo;
		int      hi;
		int      step;
		int      track;
		int      value;
		int      kind;
		result_t none;
		none = '0;
		lo = int'(shadow_cfg.min_distance);
		hi = int'(shadow_cfg.max_distance);
		step = int'(shadow_cfg.max_jump) / 2 + 4;
		if (step > 3000) step = 3000;
		track = (lo <= hi) ? int'($urandom_range(lo, hi)) : int'($urandom_range(0, 65535));
		if ($urandom_range(0, 1) == 0) send_item(ACT_CLEAR, SAMPLE_BITS'($urandom), 0, none);
		for (int n = 0; n < n_items; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 68) begin
				if (lo <= hi) begin
					track = track + int'($urandom_range(0, 2 * step)) - step;
					if (track < lo) track = lo;
					if (track > hi) track = hi;
				end else begin
					track = $urandom_range(0, 65535);
				end
				send_item(ACT_FILTER, SAMPLE_BITS'(track), 0, none);
			end else if (kind < 78) begin
				value = int'(shadow_cfg.max_jump) + int'($urandom_range(1, 2000));
				value = ($urandom_range(0, 1) == 0) ? track + value : track - value;
				if (value < 0) value = 0;
				if (value > 65535) value = 65535;
				send_item(ACT_FILTER, SAMPLE_BITS'(value), 0, none);
			end else if (kind < 86) begin
				send_item(ACT_FILTER, SAMPLE_BITS'($urandom), 0, none);
			end else if (kind < 90) begin
				if ($urandom_range(0, 1) == 0 && lo > 0) value = lo - 1;
				else if (hi < 65535) value = hi + 1;
				else value = $urandom_range(0, 65535);
				send_item(ACT_FILTER, SAMPLE_BITS'(value), 0, none);
			end else if (kind < 94) begin
				value = ($urandom_range(0, 1) == 0) ? track : int'($urandom_range(0, 65535));
				send_item(ACT_SEED, SAMPLE_BITS'(value), 0, none);
			end else if (kind < 96) begin
				send_item(ACT_CLEAR, SAMPLE_BITS'($urandom), 0, none);
			end else begin
				send_item(ACT_UNDEFINED, SAMPLE_BITS'($urandom), 0, none);
			end
		end
	endtask

	// The result side stalls in bursts; quiet phases leave it free running.
	initial begin : result_stall_driver
		int run;
		@(posedge arst_n);
		forever begin
			run = idle_length();
			if (run > 0) begin
				result_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, filtered", 32'(filtered),
					32'(0));
			end else begin
				want = expected_results.pop_front();
				if (filtered !== want.filtered)
					report_mismatch("filtered", 32'(filtered), 32'(want.filtered));
				if (in_range !== want.in_range)
					report_mismatch("in_range", 32'(in_range), 32'(want.in_range));
				if (jump_rejected !== want.jump_rejected)
					report_mismatch("jump_rejected", 32'(jump_rejected),
						32'(want.jump_rejected));
				if (primed !== want.primed)
					report_mismatch("primed", 32'(primed), 32'(want.primed));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
			|| (psel && penable && pready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, expected_results.size());
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		result_t want;
		int      lo;
		int      hi;
		int      offset;
		directed_rows = '{
			// Unprimed filter: misses and the undefined action leave everything at zero.
			'{ACT_FILTER,    16'd0,     1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd65535, 1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_UNDEFINED, 16'd1234,  1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd19,    1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			// First valid sample at the lower bound primes every stage.
			'{ACT_FILTER,    16'd20,    1'b1, 16'd20,    1'b1, 1'b0, 1'b1},
			'{ACT_FILTER,    16'd2000,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd2000,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd2001,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_UNDEFINED, 16'd0,     1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_SEED,      16'd65535, 1'b1, 16'd65535, 1'b1, 1'b0, 1'b1},
			'{ACT_FILTER,    16'd2001,  1'b1, 16'd65535, 1'b0, 1'b0, 1'b1},
			'{ACT_FILTER,    16'd1000,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_SEED,      16'd0,     1'b1, 16'd0,     1'b1, 1'b0, 1'b1},
			'{ACT_FILTER,    16'd200,   1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			// A median change of exactly max_jump is still accepted.
			'{ACT_FILTER,    16'd200,   1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd401,   1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_CLEAR,     16'd65535, 1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_SEED,      16'd1000,  1'b1, 16'd1000,  1'b1, 1'b0, 1'b1},
			'{ACT_FILTER,    16'd1201,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd1201,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_FILTER,    16'd1000,  1'b0, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_CLEAR,     16'd0,     1'b1, 16'd0,     1'b0, 1'b0, 1'b0},
			'{ACT_UNDEFINED, 16'd65535, 1'b1, 16'd0,     1'b0, 1'b0, 1'b0}
		};
		shadow_cfg.min_distance       = rsmef_pkg::RST_MIN_DISTANCE;
		shadow_cfg.max_distance       = rsmef_pkg::RST_MAX_DISTANCE;
		shadow_cfg.max_jump           = rsmef_pkg::RST_MAX_JUMP;
		shadow_cfg.calibration_offset = rsmef_pkg::RST_CAL_OFFSET;
		shadow_cfg.ema_alpha          = rsmef_pkg::RST_EMA_ALPHA;
		clear_filter_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		foreach (directed_rows[i]) begin
			want.filtered      = directed_rows[i].want_filtered;
			want.in_range      = directed_rows[i].want_in_range;
			want.jump_rejected = directed_rows[i].want_rejected;
			want.primed        = directed_rows[i].want_primed;
			send_item(directed_rows[i].act, directed_rows[i].value, directed_rows[i].typed,
				want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: apply_settings(0, 65535, 65535, 32767, 256);
				1: apply_settings(0, 65535, 0, -32768, 0);
				2: apply_settings(65535, 65535, 100, 5, 511);
				3: apply_settings(1500, 600, 200, 0, 77);
				4: apply_settings(100, 3000, 300, -150, 257);
				5: apply_settings(50, 900, 60, 40, 128);
				default: begin
					lo = $urandom_range(0, 4000);
					hi = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
						: lo + int'($urandom_range(10, 20000));
					if (hi > 65535) hi = 65535;
					offset = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
						: int'($urandom_range(0, 600)) - 300;
					apply_settings(lo, hi, $urandom_range(0, 800), offset, $urandom_range(0, 511));
				end
			endcase
			run_phase(PHASE_ITEMS);
		end

		wait_until_drained();
		$display("Covered %0d items (%0d from the table) and %0d results over %0d settings.",
			items_sent, NUM_DIRECTED, results_checked, settings_used + 1);
		$display("Seen: %0d jump rejections, %0d range misses, %0d seeds, %0d clears.",
			rejects_seen, out_of_range, seeds_sent, clears_sent);
		if (error_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/rsmef_pkg.sv
src/rsmef_cfg_regs.sv
src/rsmef_core.sv
src/range_sensor_median_ema_filter_unit.sv
tb/sv/testbench.sv
